/* rtl/spp_pkg.sv */
// ----------------------------------------------------------------------------
// spp_pkg: shared types, constants and a function for the six-button pad select logic
// Holds the opcode codes, the per-pad state entry and the port read decoder.
// ----------------------------------------------------------------------------
package spp_pkg;

    localparam int PADS_DFLT       = 8;
    localparam int IDLE_LIMIT_DFLT = 25;
    localparam int PAD_IDX_W       = 3;
    localparam int MASK_W          = 8;
    localparam int WDATA_W         = 8;
    localparam int BTN_W           = 12;
    localparam int RDATA_W         = 7;
    localparam int EDGE_W          = 2;
    localparam int IDLE_W          = 5;
    localparam int TH_BIT          = 6;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam int BTN_UP    = 0;
    localparam int BTN_DOWN  = 1;
    localparam int BTN_LEFT  = 2;
    localparam int BTN_RIGHT = 3;
    localparam int BTN_A     = 4;
    localparam int BTN_B     = 5;
    localparam int BTN_C     = 6;
    localparam int BTN_START = 7;
    localparam int BTN_X     = 8;
    localparam int BTN_Y     = 9;
    localparam int BTN_Z     = 10;
    localparam int BTN_MODE  = 11;

    localparam logic [RDATA_W-1:0] RD_IDLE = 7'h7F;

    typedef struct packed {
        logic              th;
        logic [EDGE_W-1:0] edge_cnt;
        logic [IDLE_W-1:0] idle;
    } t_entry;

    localparam int     ENTRY_W   = $bits(t_entry);
    localparam t_entry ENTRY_RST = '{th: 1'b1, edge_cnt: '0, idle: '0};

    function automatic logic [RDATA_W-1:0] pad_read(
        input logic              th,
        input logic [EDGE_W-1:0] edge_cnt,
        input logic              six,
        input logic [BTN_W-1:0]  btns
    );
        logic [2:0]         phase;
        logic [BTN_W-1:0]   n;
        logic [RDATA_W-1:0] v;
        phase = {(six ? edge_cnt : 2'b00), th};
        n     = ~btns;
        case (phase)
            3'd0, 3'd2: v = {1'b0, n[BTN_START], n[BTN_A], 2'b00, n[BTN_DOWN], n[BTN_UP]};
            3'd4:       v = {1'b0, n[BTN_START], n[BTN_A], 4'b0000};
            3'd6:       v = {1'b0, n[BTN_START], n[BTN_A], 4'b1111};
            3'd7:       v = {1'b1, n[BTN_C], n[BTN_B], n[BTN_MODE], n[BTN_X], n[BTN_Y],
                             n[BTN_Z]};
            default:    v = {1'b1, n[BTN_C], n[BTN_B], n[BTN_RIGHT], n[BTN_LEFT],
                             n[BTN_DOWN], n[BTN_UP]};
        endcase
        return v;
    endfunction

endpackage

/* rtl/spp_in_if.sv */
// ----------------------------------------------------------------------------
// spp_in_if: pad access channel
// Carries one port access or frame tick per transaction.
// ----------------------------------------------------------------------------
interface spp_in_if;
    import spp_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [1:0]           opcode;
    logic [PAD_IDX_W-1:0] pad_index;
    logic [WDATA_W-1:0]   write_data;
    logic [BTN_W-1:0]     buttons;

    modport source (output valid, opcode, pad_index, write_data, buttons, input ready);
    modport sink   (input valid, opcode, pad_index, write_data, buttons, output ready);
endinterface

/* rtl/spp_out_if.sv */
// ----------------------------------------------------------------------------
// spp_out_if: port read result channel
// Carries the seven active-low port bits of one read per transaction.
// ----------------------------------------------------------------------------
interface spp_out_if;
    import spp_pkg::*;

    logic               valid;
    logic               ready;
    logic [RDATA_W-1:0] read_data;

    modport source (output valid, read_data, input ready);
    modport sink   (input valid, read_data, output ready);
endinterface

/* rtl/spp_ram.sv */
// ----------------------------------------------------------------------------
// spp_ram: generic single-write, single-read RAM
// Registered read data, held while the read enable is low.
// ----------------------------------------------------------------------------
module spp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/six_button_pad_protocol_top.sv */
// ----------------------------------------------------------------------------
// six_button_pad_protocol_top: six-button pad select-line multiplexer
// A read result is registered once its stage entry fires. Throughput: 1 transaction
// per cycle unless stalled; the state RAM read-modify-write is forwarded.
// A read held back by a full, stalled output register blocks new transactions.
// Reset: synchronous, active low; all pads return to TH high, counts zero,
// through per-pad valid bits; the mask clears to three-button pads.
// ----------------------------------------------------------------------------
module six_button_pad_protocol_top #(
    parameter int NUM_PADS   = spp_pkg::PADS_DFLT,
    parameter int IDLE_LIMIT = spp_pkg::IDLE_LIMIT_DFLT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [spp_pkg::MASK_W-1:0] i_cfg_wdata,
    spp_in_if.sink                     i_in,
    spp_out_if.source                  o_out
);
    import spp_pkg::*;

    localparam int AW = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    logic [MASK_W-1:0]    r_mask;
    logic [NUM_PADS-1:0]  r_vld;

    logic                 r_s1_valid;
    logic [1:0]           r_s1_op;
    logic                 r_s1_inrange;
    logic                 r_s1_six;
    logic                 r_s1_th;
    logic [BTN_W-1:0]     r_s1_btns;
    logic [AW-1:0]        r_s1_addr;
    logic                 r_s1_hit;
    logic                 r_fwd;
    t_entry               r_fwd_data;

    logic                 r_out_valid;
    logic [RDATA_W-1:0]   r_out_data;

    logic                 in_accept;
    logic                 in_inrange;
    logic [AW-1:0]        in_addr;
    logic [ENTRY_W-1:0]   ram_rdata;
    t_entry               cur;
    t_entry               n_entry;
    logic                 s1_is_read;
    logic                 s1_fire;
    logic                 s1_we;

    assign in_inrange = ({1'b0, i_in.pad_index} < (PAD_IDX_W + 1)'(NUM_PADS));
    assign in_addr    = i_in.pad_index[AW-1:0];
    assign in_accept  = i_in.valid && i_in.ready;

    spp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_PADS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (s1_we),
        .i_waddr (r_s1_addr),
        .i_wdata (n_entry),
        .i_re    (in_accept && in_inrange),
        .i_raddr (in_addr),
        .o_rdata (ram_rdata)
    );

    assign cur        = r_fwd ? r_fwd_data : (r_s1_hit ? t_entry'(ram_rdata) : ENTRY_RST);
    assign s1_is_read = (r_s1_op == OP_READ);
    assign s1_fire    = r_s1_valid && (!s1_is_read || !r_out_valid || o_out.ready);
    assign s1_we      = s1_fire && r_s1_inrange &&
                        ((r_s1_op == OP_WRITE) || ((r_s1_op == OP_TICK) && r_s1_six));
    assign i_in.ready = !r_s1_valid || s1_fire;

    always_comb begin
        n_entry = cur;
        case (r_s1_op)
            OP_WRITE: begin
                if (r_s1_six && !cur.th && r_s1_th) begin
                    n_entry.edge_cnt = cur.edge_cnt + 1'b1;
                    n_entry.idle     = '0;
                end
                n_entry.th = r_s1_th;
            end
            OP_TICK: begin
                if (cur.idle > IDLE_W'(IDLE_LIMIT)) begin
                    n_entry.idle     = '0;
                    n_entry.edge_cnt = '0;
                end else begin
                    n_entry.idle = cur.idle + 1'b1;
                end
            end
            default: n_entry = cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_vld       <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mask <= i_cfg_wdata;
            end
            if (s1_we) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= s1_we && in_inrange && (in_addr == r_s1_addr);
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
                r_fwd      <= 1'b0;
            end
            if (s1_fire && s1_is_read) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_op      <= i_in.opcode;
            r_s1_inrange <= in_inrange;
            r_s1_six     <= in_inrange && r_mask[i_in.pad_index];
            r_s1_th      <= i_in.write_data[TH_BIT];
            r_s1_btns    <= i_in.buttons;
            r_s1_addr    <= in_addr;
            r_s1_hit     <= in_inrange && r_vld[in_addr];
            r_fwd_data   <= n_entry;
        end
        if (s1_fire && s1_is_read) begin
            r_out_data <= r_s1_inrange ?
                          pad_read(cur.th, cur.edge_cnt, r_s1_six, r_s1_btns) : RD_IDLE;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.read_data = r_out_data;

    a_fwd_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fwd |-> r_s1_valid)
        else $error("forwarding flag set with empty stage");

    a_we_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_we |-> ({1'b0, r_s1_addr} < (AW + 1)'(NUM_PADS)))
        else $error("state write outside pad range");

    a_oor_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && s1_is_read && !r_s1_inrange) |=> (r_out_data == RD_IDLE))
        else $error("out-of-range read did not return idle pattern");

    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(s1_fire && s1_is_read))
        else $error("result raised without a read transaction");
endmodule
